[sv/bffa_pkg.sv]
// Shared types, constants and helpers for the bitmap first-free allocator.
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int RESERVED_DEF = 1;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 10;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ROOT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     granted_index;
    logic [CNT_OUT_W-1:0] free_left;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

  function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] word);
    logic [4:0] pos;
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        pos = 5'(b);
      end
    end
    return pos;
  endfunction

endpackage

[sv/bffa_map.sv]
// Used-bit map RAM with post-reset initialization sweep.
`timescale 1ns / 1ps

module bffa_map #(
  parameter int ENTRIES  = bffa_pkg::ENTRIES_DEF,
  parameter int RESERVED = bffa_pkg::RESERVED_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bffa_pkg::map_ctl_t                ctl,
  input  logic [((ENTRIES + 31) / 32 > 1 ? $clog2((ENTRIES + 31) / 32) : 1)-1:0] rd_addr,
  input  logic [((ENTRIES + 31) / 32 > 1 ? $clog2((ENTRIES + 31) / 32) : 1)-1:0] wr_addr,
  input  logic [bffa_pkg::WORD_W-1:0]       wr_data,
  output logic [bffa_pkg::WORD_W-1:0]       rd_data,
  output logic                              ready
);
  import bffa_pkg::*;

  localparam int WORDS   = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RES_EFF = (RESERVED > ENTRIES) ? ENTRIES : RESERVED;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  logic [WORD_W-1:0] mem_r [WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [31:0]       clr_base;
  logic [WORD_W-1:0] init_word;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  always_comb begin
    clr_base = 32'({clr_addr_r, 5'b0});
    for (int b = 0; b < WORD_W; b++) begin
      init_word[b] = ((clr_base + 32'(b)) < 32'(RES_EFF)) ||
                     ((clr_base + 32'(b)) >= 32'(ENTRIES));
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == LAST_WORD) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
    we    = clr_busy_r || ctl.wr_en;
    waddr = clr_busy_r ? clr_addr_r : wr_addr;
    wdata = clr_busy_r ? init_word : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

[sv/bitmap_first_free_allocator.sv]
// Top level of the bitmap first-free allocator: request sequencer and result register.
`timescale 1ns / 1ps

// Usage: one request word enters on in_* (valid/stall); one result word leaves on out_*.
// Allocate (req_type 0) grants the lowest free entry; free (req_type 1) releases
// entry_index. Entry 0 can never be freed; entries below RESERVED start out used.
// The used bits sit in a RAM of 32-bit words, one word read per cycle.
// A full pool, the root, or an out-of-range entry goes straight to the done state;
// a free first reads its word in the free-check state; an allocate scans the words
// in order from word 0, k of them (1 to ENTRIES/32 rounded up), up to the word
// that holds the first clear bit.
// One request is in flight at a time; in_stall is high from accept until the
// result moves into the output register.
// After reset the RAM is swept once, one word per cycle; in_stall stays high for the
// sweep and falls in the cycle after the map reports ready.
// A stalled result holds in the output register; the next request may be
// accepted and worked on meanwhile, but its result waits for the register.
module bitmap_first_free_allocator #(
  parameter int ENTRIES  = bffa_pkg::ENTRIES_DEF,
  parameter int RESERVED = bffa_pkg::RESERVED_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bffa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bffa_pkg::out_word_t out_data
);
  import bffa_pkg::*;

  localparam int WORDS   = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int RES_EFF = (RESERVED > ENTRIES) ? ENTRIES : RESERVED;
  localparam logic [CW-1:0] CNT_INIT  = CW'(ENTRIES - RES_EFF);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_FCHK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [AW-1:0]     chk_addr_r, chk_addr_nxt;
  logic [IDX_W-1:0]  req_idx_r, req_idx_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_gnt_r, res_gnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  map_ctl_t          map_ctl;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;
  logic              map_ready;

  logic [31:0]       idx_ext;
  logic [31:0]       gnt_full;
  logic [31:0]       cnt_ext;
  logic [4:0]        ffz_pos;
  logic [4:0]        bit_sel;
  logic              hit_word;

  bffa_map #(
    .ENTRIES  (ENTRIES),
    .RESERVED (RESERVED)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (map_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .ready   (map_ready)
  );

  always_comb begin
    state_nxt      = state_r;
    free_cnt_nxt   = free_cnt_r;
    chk_addr_nxt   = chk_addr_r;
    req_idx_nxt    = req_idx_r;
    res_status_nxt = res_status_r;
    res_gnt_nxt    = res_gnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    map_ctl        = '0;
    rd_addr        = '0;
    wr_addr        = chk_addr_r;
    wr_data        = rd_data;

    idx_ext  = 32'(in_data.entry_index);
    ffz_pos  = first_zero(rd_data);
    hit_word = ~&rd_data;
    bit_sel  = req_idx_r[4:0];
    gnt_full = 32'({chk_addr_r, ffz_pos});
    cnt_ext  = 32'(free_cnt_r);
    in_stall = (state_r != S_IDLE);

    unique case (state_r)
      S_INIT: begin
        if (map_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_idx_nxt    = in_data.entry_index;
          res_gnt_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_data.req_type == REQ_ALLOC) begin
            if (free_cnt_r == '0) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              map_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              chk_addr_nxt  = '0;
              state_nxt     = S_SCAN;
            end
          end else if (in_data.entry_index == '0) begin
            res_status_nxt = ST_ROOT;
            state_nxt      = S_DONE;
          end else if (idx_ext >= 32'(ENTRIES)) begin
            res_status_nxt = ST_BADFREE;
            state_nxt      = S_DONE;
          end else begin
            map_ctl.rd_en = 1'b1;
            rd_addr       = idx_ext[AW+4:5];
            chk_addr_nxt  = idx_ext[AW+4:5];
            state_nxt     = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (hit_word) begin
          map_ctl.wr_en = 1'b1;
          wr_data       = rd_data | (WORD_W'(1) << ffz_pos);
          free_cnt_nxt  = free_cnt_r - CW'(1);
          res_gnt_nxt   = gnt_full[IDX_W-1:0];
          state_nxt     = S_DONE;
        end else if (chk_addr_r == LAST_WORD) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          map_ctl.rd_en = 1'b1;
          rd_addr       = chk_addr_r + AW'(1);
          chk_addr_nxt  = chk_addr_r + AW'(1);
        end
      end
      S_FCHK: begin
        if (rd_data[bit_sel]) begin
          map_ctl.wr_en = 1'b1;
          wr_data       = rd_data & ~(WORD_W'(1) << bit_sel);
          free_cnt_nxt  = free_cnt_r + CW'(1);
        end else begin
          res_status_nxt = ST_BADFREE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.granted_index = res_gnt_r;
          out_data_nxt.free_left     = cnt_ext[CNT_OUT_W-1:0];
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      free_cnt_r  <= CNT_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r   <= chk_addr_nxt;
    req_idx_r    <= req_idx_nxt;
    res_status_r <= res_status_nxt;
    res_gnt_r    <= res_gnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    map_ctl.wr_en |-> (state_r == S_SCAN || state_r == S_FCHK))
    else $error("map write outside scan or free check");

  a_scan_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (free_cnt_r != '0))
    else $error("scan running with zero free count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_cnt_r) <= 32'(ENTRIES))
    else $error("free count above pool size");

  a_grant_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.granted_index != '0) |-> (out_data_r.status == ST_OK))
    else $error("nonzero grant with error status");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside done state");

endmodule

[test/tb_bitmap_first_free_allocator.sv]
// Testbench for the bitmap first-free allocator: directed table, then random words checked by a pool predictor.
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator;
  import bffa_pkg::*;

  localparam int POOL_SIZE = ENTRIES_DEF;
  localparam int POOL_RSVD = RESERVED_DEF;
  localparam int DIR_ROWS = 16;
  localparam int PHASE_WORDS = 617;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic                 req;
    logic [IDX_W-1:0]     idx;
    logic                 typed;
    logic [STAT_W-1:0]    st;
    logic [IDX_W-1:0]     gi;
    logic [CNT_OUT_W-1:0] fl;
  } dir_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  bit          pool_used [POOL_SIZE];
  int unsigned pool_free;
  out_word_t   awaited_results [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{REQ_ALLOC, 10'd0,     1'b1, ST_OK,      10'd1, 11'd1022},
    '{REQ_ALLOC, 10'd1023,  1'b1, ST_OK,      10'd2, 11'd1021},
    '{REQ_FREE,  10'd0,     1'b1, ST_ROOT,    10'd0, 11'd1021},
    '{REQ_FREE,  10'd1023,  1'b1, ST_BADFREE, 10'd0, 11'd1021},
    '{REQ_FREE,  10'd1,     1'b1, ST_OK,      10'd0, 11'd1022},
    '{REQ_FREE,  10'd1,     1'b1, ST_BADFREE, 10'd0, 11'd1022},
    '{REQ_ALLOC, 10'h155,   1'b1, ST_OK,      10'd1, 11'd1021},
    '{REQ_ALLOC, 10'h2aa,   1'b1, ST_OK,      10'd3, 11'd1020},
    '{REQ_FREE,  10'd2,     1'b1, ST_OK,      10'd0, 11'd1021},
    '{REQ_ALLOC, 10'd0,     1'b1, ST_OK,      10'd2, 11'd1020},
    '{REQ_FREE,  10'h200,   1'b1, ST_BADFREE, 10'd0, 11'd1020},
    '{REQ_FREE,  10'h3fe,   1'b1, ST_BADFREE, 10'd0, 11'd1020},
    '{REQ_FREE,  10'd3,     1'b0, ST_OK,      10'd0, 11'd0},
    '{REQ_ALLOC, 10'h3ff,   1'b0, ST_OK,      10'd0, 11'd0},
    '{REQ_FREE,  10'h155,   1'b0, ST_OK,      10'd0, 11'd0},
    '{REQ_ALLOC, 10'h0ff,   1'b0, ST_OK,      10'd0, 11'd0}
  };

  bitmap_first_free_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_bitmap_first_free_allocator NOT OK");
    $finish;
  end

  function automatic out_word_t predict_grant(input in_word_t w);
    out_word_t r;
    bit        found;
    r = '0;
    found = 1'b0;
    if (w.req_type == REQ_ALLOC) begin
      if (pool_free != 0) begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (!found && !pool_used[i]) begin
            pool_used[i] = 1'b1;
            pool_free--;
            r.granted_index = IDX_W'(i);
            found = 1'b1;
          end
        end
      end
      r.status = found ? ST_OK : ST_FULL;
    end else if (w.entry_index == 0) begin
      r.status = ST_ROOT;
    end else if (int'(w.entry_index) >= POOL_SIZE || !pool_used[w.entry_index]) begin
      r.status = ST_BADFREE;
    end else begin
      pool_used[w.entry_index] = 1'b0;
      pool_free++;
      r.status = ST_OK;
    end
    r.free_left = CNT_OUT_W'(pool_free);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_used_entry();
    int start;
    int k;
    start = $urandom_range(1, POOL_SIZE - 1);
    for (int n = 0; n < POOL_SIZE; n++) begin
      k = (start + n) % POOL_SIZE;
      if (k != 0 && pool_used[k]) return IDX_W'(k);
    end
    return IDX_W'(start);
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    int gap;
    out_word_t predicted;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_grant(w);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result word: status %0d granted_index %0d free_left %0d",
             got.status, got.granted_index, got.free_left);
      mismatch_count++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.granted_index !== want.granted_index) begin
      $error("granted_index: expected %0d, actual %0d", want.granted_index, got.granted_index);
      mismatch_count++;
    end
    if (got.free_left !== want.free_left) begin
      $error("free_left: expected %0d, actual %0d", want.free_left, got.free_left);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  initial begin
    in_word_t  w;
    out_word_t typed_res;
    int        alloc_pct;
    for (int i = 0; i < POOL_SIZE; i++) pool_used[i] = (i < POOL_RSVD);
    pool_free = POOL_SIZE - POOL_RSVD;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_stall_pct = 49;
    for (int r = 0; r < DIR_ROWS; r++) begin
      w.req_type = dir_table[r].req;
      w.entry_index = dir_table[r].idx;
      typed_res.status = dir_table[r].st;
      typed_res.granted_index = dir_table[r].gi;
      typed_res.free_left = dir_table[r].fl;
      send_word(w, dir_table[r].typed, typed_res);
    end
    for (int p = 0; p < 3; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      @(posedge clk);
      case (p)
        0: begin
          send_idle_pct = 26;
          recv_stall_pct = 49;
          alloc_pct = 90;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 26;
          alloc_pct = 97;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          alloc_pct = 30;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          w.req_type = REQ_ALLOC;
          w.entry_index = IDX_W'($urandom_range(0, 1023));
        end else begin
          w.req_type = REQ_FREE;
          if ($urandom_range(0, 99) < 15) w.entry_index = IDX_W'($urandom_range(0, 1023));
          else w.entry_index = pick_used_entry();
        end
        send_word(w, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_bitmap_first_free_allocator OK");
    end else begin
      $display("tb_bitmap_first_free_allocator NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
sv/bffa_pkg.sv
sv/bffa_map.sv
sv/bitmap_first_free_allocator.sv
test/tb_bitmap_first_free_allocator.sv
